### design/semantic_version_parser_core_macros.svh
// Assertion macros for the semantic version parser
`ifndef SEMANTIC_VERSION_PARSER_CORE_MACROS_SVH
`define SEMANTIC_VERSION_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held
`define SVP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("svp check failed");
// Clocked check that also holds through reset
`define SVP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("svp check failed");
`else
`define SVP_ASSERT_RST(lbl, prop)
`define SVP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/svp_pkg.sv
// Types and constants shared by the semantic version parser
package svp_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FORMAT   = 3'd2;
  localparam logic [2:0] ST_MAJOR    = 3'd3;
  localparam logic [2:0] ST_MINOR    = 3'd4;
  localparam logic [2:0] ST_PATCH    = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;
  localparam logic [2:0] ST_PRE      = 3'd7;

  // Character codes
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;

  localparam logic [15:0] PRE_CNT_MAX = 16'hFFFF;

  // One byte of the version string, or the end marker
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_string;
  } in_item_t;

  // One parse result
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] major_value;
    logic [31:0] minor_value;
    logic [31:0] patch_value;
    logic        has_prerelease;
    logic [15:0] prerelease_length;
  } out_item_t;

endpackage

### design/semantic_version_parser_core.sv
// Semantic version parser: streamed major.minor.patch[-prerelease] checker
//
//  channel | direction | payload              | flow control
//  --------+-----------+----------------------+---------------------------
//  in_     | input     | svp_pkg::in_item_t   | in_valid / in_stall
//  out_    | output    | svp_pkg::out_item_t  | out_valid / out_stall
//
// One item is taken every cycle unless stalled; bytes update the parser state in
// the cycle after transfer, out of the input register, and never wait on results.
// An end marker needs the result register free; its result is registered into it
// from the input register, and the parser state returns to its reset value then.
// Reset (synchronous, active low) clears the parser state and both valid flags.
// While out_stall holds a result and an end marker is queued, in_stall rises.
`include "semantic_version_parser_core_macros.svh"

module semantic_version_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  svp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output svp_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    PH_MAJOR,
    PH_MINOR,
    PH_PATCH,
    PH_PRE
  } phase_t;

  // Input register
  logic               in_vld_r;
  svp_pkg::in_item_t  in_item_r;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [31:0] major_r, major_nxt;
  logic [31:0] minor_r, minor_nxt;
  logic [31:0] patch_r, patch_nxt;
  logic [1:0]  part_len_r, part_len_nxt;
  logic        lead_zero_r, lead_zero_nxt;
  logic        nondigit_r, nondigit_nxt;
  logic        ovf_r, ovf_nxt;
  logic [2:0]  first_err_r, first_err_nxt;
  logic        any_byte_r, any_byte_nxt;
  logic [15:0] pre_cnt_r, pre_cnt_nxt;
  logic        pre_bad_r, pre_bad_nxt;

  // Result register
  logic               out_vld_r;
  svp_pkg::out_item_t out_item_r;
  svp_pkg::out_item_t res;

  logic        adv;
  logic        out_free;
  logic        is_end;
  logic [7:0]  c;
  logic        is_digit;
  logic        pre_ok;
  logic [31:0] num_cur;
  logic [35:0] times10;
  logic        acc_ovf;
  logic [31:0] acc_val;
  logic [2:0]  close_code;
  logic [2:0]  close_err;
  logic [2:0]  final_err;
  logic [2:0]  status;

  // Handshake: bytes always advance, end markers need the result register
  assign is_end   = in_item_r.end_of_string;
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && (!is_end || out_free);
  assign in_stall = in_vld_r && !adv;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // Byte classes
  assign c        = in_item_r.character;
  assign is_digit = (c >= svp_pkg::CH_0) && (c <= svp_pkg::CH_9);
  assign pre_ok   = is_digit || (c == svp_pkg::CH_DOT) || (c == svp_pkg::CH_DASH) ||
                    ((c >= svp_pkg::CH_LA) && (c <= svp_pkg::CH_LZ)) ||
                    ((c >= svp_pkg::CH_UA) && (c <= svp_pkg::CH_UZ));

  // Times-ten accumulate on the number being parsed
  always_comb begin
    unique case (phase_r)
      PH_MAJOR: num_cur = major_r;
      PH_MINOR: num_cur = minor_r;
      default:  num_cur = patch_r;
    endcase
  end

  assign times10 = {1'b0, num_cur, 3'b000} + {3'b000, num_cur, 1'b0} + {32'd0, c[3:0]};
  assign acc_ovf = |times10[35:32];
  assign acc_val = acc_ovf ? 32'hFFFF_FFFF : times10[31:0];

  // Error of the number being closed
  always_comb begin
    unique case (phase_r)
      PH_MAJOR: close_code = svp_pkg::ST_MAJOR;
      PH_MINOR: close_code = svp_pkg::ST_MINOR;
      default:  close_code = svp_pkg::ST_PATCH;
    endcase
  end

  always_comb begin
    priority if ((part_len_r == 2'd0) || ((part_len_r == 2'd2) && lead_zero_r) ||
                 nondigit_r) begin
      close_err = close_code;
    end else if (ovf_r) begin
      close_err = svp_pkg::ST_OVERFLOW;
    end else begin
      close_err = svp_pkg::ST_OK;
    end
  end

  // Result of an end marker, by precedence
  always_comb begin
    final_err = first_err_r;
    if ((phase_r == PH_PATCH) && (first_err_r == svp_pkg::ST_OK)) begin
      final_err = close_err;
    end
    priority if (!any_byte_r) begin
      status = svp_pkg::ST_EMPTY;
    end else if ((phase_r == PH_MAJOR) || (phase_r == PH_MINOR)) begin
      status = svp_pkg::ST_FORMAT;
    end else if (final_err != svp_pkg::ST_OK) begin
      status = final_err;
    end else if ((phase_r == PH_PRE) && ((pre_cnt_r == 16'd0) || pre_bad_r)) begin
      status = svp_pkg::ST_PRE;
    end else begin
      status = svp_pkg::ST_OK;
    end

    res        = '0;
    res.status = status;
    if (status == svp_pkg::ST_OK) begin
      res.major_value = major_r;
      res.minor_value = minor_r;
      res.patch_value = patch_r;
      if (phase_r == PH_PRE) begin
        res.has_prerelease    = 1'b1;
        res.prerelease_length = pre_cnt_r;
      end
    end
  end

  // Parser state update
  always_comb begin
    phase_nxt     = phase_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    patch_nxt     = patch_r;
    part_len_nxt  = part_len_r;
    lead_zero_nxt = lead_zero_r;
    nondigit_nxt  = nondigit_r;
    ovf_nxt       = ovf_r;
    first_err_nxt = first_err_r;
    any_byte_nxt  = any_byte_r;
    pre_cnt_nxt   = pre_cnt_r;
    pre_bad_nxt   = pre_bad_r;

    if (adv && is_end) begin
      // string closed: back to the reset state
      phase_nxt     = PH_MAJOR;
      major_nxt     = '0;
      minor_nxt     = '0;
      patch_nxt     = '0;
      part_len_nxt  = '0;
      lead_zero_nxt = 1'b0;
      nondigit_nxt  = 1'b0;
      ovf_nxt       = 1'b0;
      first_err_nxt = svp_pkg::ST_OK;
      any_byte_nxt  = 1'b0;
      pre_cnt_nxt   = '0;
      pre_bad_nxt   = 1'b0;
    end else if (adv) begin
      any_byte_nxt = 1'b1;
      priority if (((phase_r == PH_MAJOR) && (c == svp_pkg::CH_DOT)) ||
                   ((phase_r == PH_MINOR) && (c == svp_pkg::CH_DOT)) ||
                   ((phase_r == PH_PATCH) && (c == svp_pkg::CH_DASH))) begin
        // separator: close the number, move on
        if (first_err_r == svp_pkg::ST_OK) begin
          first_err_nxt = close_err;
        end
        part_len_nxt  = '0;
        lead_zero_nxt = 1'b0;
        nondigit_nxt  = 1'b0;
        ovf_nxt       = 1'b0;
        phase_nxt     = phase_t'(phase_r + 2'd1);
      end else if (phase_r == PH_PRE) begin
        if (pre_cnt_r != svp_pkg::PRE_CNT_MAX) begin
          pre_cnt_nxt = pre_cnt_r + 16'd1;
        end
        if (!pre_ok) begin
          pre_bad_nxt = 1'b1;
        end
      end else begin
        // number byte
        if ((part_len_r == 2'd0) && (c == svp_pkg::CH_0)) begin
          lead_zero_nxt = 1'b1;
        end
        if (part_len_r != 2'd2) begin
          part_len_nxt = part_len_r + 2'd1;
        end
        if (is_digit) begin
          if (acc_ovf) begin
            ovf_nxt = 1'b1;
          end
          unique case (phase_r)
            PH_MAJOR: major_nxt = acc_val;
            PH_MINOR: minor_nxt = acc_val;
            default:  patch_nxt = acc_val;
          endcase
        end else begin
          nondigit_nxt = 1'b1;
        end
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      phase_r     <= PH_MAJOR;
      major_r     <= '0;
      minor_r     <= '0;
      patch_r     <= '0;
      part_len_r  <= '0;
      lead_zero_r <= 1'b0;
      nondigit_r  <= 1'b0;
      ovf_r       <= 1'b0;
      first_err_r <= svp_pkg::ST_OK;
      any_byte_r  <= 1'b0;
      pre_cnt_r   <= '0;
      pre_bad_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      patch_r     <= patch_nxt;
      part_len_r  <= part_len_nxt;
      lead_zero_r <= lead_zero_nxt;
      nondigit_r  <= nondigit_nxt;
      ovf_r       <= ovf_nxt;
      first_err_r <= first_err_nxt;
      any_byte_r  <= any_byte_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      pre_bad_r   <= pre_bad_nxt;

      // input register takes a transfer whenever it is not held
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end

      // result register
      if (adv && is_end) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end

    // payload registers
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
    if (adv && is_end) begin
      out_item_r <= res;
    end
  end

  // Checks
  `SVP_ASSERT_RST(a_err_zero, (out_vld_r && (out_item_r.status != svp_pkg::ST_OK)) |-> ((out_item_r.major_value == 32'd0) && (out_item_r.minor_value == 32'd0) && (out_item_r.patch_value == 32'd0) && !out_item_r.has_prerelease))
  `SVP_ASSERT_RST(a_end_clears, (adv && is_end) |=> ((phase_r == PH_MAJOR) && !any_byte_r && (first_err_r == svp_pkg::ST_OK)))
  `SVP_ASSERT_ALWAYS(a_stall_cause, in_stall |-> (in_vld_r && is_end && out_vld_r))
  `SVP_ASSERT_RST(a_pre_len, (out_vld_r && out_item_r.has_prerelease) |-> (out_item_r.prerelease_length != 16'd0))

endmodule

### tb/tb_semantic_version_parser_core.sv
// Self-checking testbench for the streamed semantic version parser
module tb_semantic_version_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 100_000;

  // Which part of the version string the parser is in
  typedef enum logic [1:0] {
    PART_MAJOR,
    PART_MINOR,
    PART_PATCH,
    PART_PRE
  } part_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  svp_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  svp_pkg::out_item_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Results still owed by the block, oldest first
  svp_pkg::out_item_t expected_versions[$];

  // Parser state as the testbench tracks it
  part_t       cur_part;
  logic [31:0] acc_value [3];
  int unsigned digits_in_part;
  logic        lead_zero;
  logic        stray_byte;
  logic        too_big;
  logic [2:0]  first_error;
  logic        got_byte;
  logic [15:0] pre_len;
  logic        pre_illegal;

  semantic_version_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Version parser prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    cur_part       = PART_MAJOR;
    acc_value[0]   = '0;
    acc_value[1]   = '0;
    acc_value[2]   = '0;
    digits_in_part = 0;
    lead_zero      = 1'b0;
    stray_byte     = 1'b0;
    too_big        = 1'b0;
    first_error    = svp_pkg::ST_OK;
    got_byte       = 1'b0;
    pre_len        = '0;
    pre_illegal    = 1'b0;
  endfunction

  // A number ends: keep its error code if it is the first one seen
  function automatic void close_number(logic [2:0] code);
    logic [2:0] err;
    err = svp_pkg::ST_OK;
    if (digits_in_part == 0 || (digits_in_part >= 2 && lead_zero) || stray_byte)
      err = code;
    else if (too_big)
      err = svp_pkg::ST_OVERFLOW;
    if (first_error == svp_pkg::ST_OK)
      first_error = err;
    digits_in_part = 0;
    lead_zero      = 1'b0;
    stray_byte     = 1'b0;
    too_big        = 1'b0;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    logic [35:0] wide;
    got_byte = 1'b1;
    if (cur_part == PART_MAJOR && c == svp_pkg::CH_DOT) begin
      close_number(svp_pkg::ST_MAJOR);
      cur_part = PART_MINOR;
    end else if (cur_part == PART_MINOR && c == svp_pkg::CH_DOT) begin
      close_number(svp_pkg::ST_MINOR);
      cur_part = PART_PATCH;
    end else if (cur_part == PART_PATCH && c == svp_pkg::CH_DASH) begin
      close_number(svp_pkg::ST_PATCH);
      cur_part = PART_PRE;
    end else if (cur_part == PART_PRE) begin
      if (pre_len != svp_pkg::PRE_CNT_MAX)
        pre_len++;
      if (!((c >= svp_pkg::CH_LA && c <= svp_pkg::CH_LZ) ||
            (c >= svp_pkg::CH_UA && c <= svp_pkg::CH_UZ) ||
            (c >= svp_pkg::CH_0 && c <= svp_pkg::CH_9) ||
            c == svp_pkg::CH_DOT || c == svp_pkg::CH_DASH))
        pre_illegal = 1'b1;
    end else begin
      // digit of major, minor or patch; times-ten add held at all ones on overflow
      if (digits_in_part == 0 && c == svp_pkg::CH_0)
        lead_zero = 1'b1;
      if (digits_in_part < 2)
        digits_in_part++;
      if (c >= svp_pkg::CH_0 && c <= svp_pkg::CH_9) begin
        wide = 36'(acc_value[cur_part]) * 36'd10 + 36'(c - svp_pkg::CH_0);
        if (wide > 36'hFFFF_FFFF) begin
          too_big               = 1'b1;
          acc_value[cur_part]   = '1;
        end else begin
          acc_value[cur_part]   = wide[31:0];
        end
      end else begin
        stray_byte = 1'b1;
      end
    end
  endfunction

  function automatic svp_pkg::out_item_t finish_version();
    svp_pkg::out_item_t r;
    logic [2:0]         st;
    if (!got_byte) begin
      st = svp_pkg::ST_EMPTY;
    end else if (cur_part == PART_MAJOR || cur_part == PART_MINOR) begin
      st = svp_pkg::ST_FORMAT;
    end else begin
      if (cur_part == PART_PATCH)
        close_number(svp_pkg::ST_PATCH);
      if (first_error != svp_pkg::ST_OK)
        st = first_error;
      else if (cur_part == PART_PRE && (pre_len == 0 || pre_illegal))
        st = svp_pkg::ST_PRE;
      else
        st = svp_pkg::ST_OK;
    end
    r        = '0;
    r.status = st;
    if (st == svp_pkg::ST_OK) begin
      r.major_value       = acc_value[PART_MAJOR];
      r.minor_value       = acc_value[PART_MINOR];
      r.patch_value       = acc_value[PART_PATCH];
      r.has_prerelease    = (cur_part == PART_PRE);
      r.prerelease_length = (cur_part == PART_PRE) ? pre_len : 16'd0;
    end
    clear_parser();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side
  // ---------------------------------------------------------------------------

  // Drives one item and returns once the block has taken it
  task automatic send_item(svp_pkg::in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (item.end_of_string)
      expected_versions.push_back(finish_version());
    else
      parse_byte(item.character);
  endtask

  task automatic send_char(logic [7:0] c);
    svp_pkg::in_item_t item;
    item.character     = c;
    item.end_of_string = 1'b0;
    send_item(item);
  endtask

  // End marker; the byte beside it is noise
  task automatic send_end();
    svp_pkg::in_item_t item;
    item.character     = 8'($urandom_range(255));
    item.end_of_string = 1'b1;
    send_item(item);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  task automatic send_version(string s);
    send_text(s);
    send_end();
  endtask

  // One decimal number, sometimes near or past 32 bits, sometimes malformed
  task automatic send_random_number();
    int unsigned     pick;
    int unsigned     mangle;
    int              cut;
    longint unsigned val;
    string           digits;
    logic [7:0]      junk;
    pick = $urandom_range(99);
    if (pick < 40)
      val = $urandom_range(20);
    else if (pick < 70)
      val = $urandom;
    else if (pick < 85)
      val = 64'hFFFF_FFFE + $urandom_range(2);
    else
      val = (64'($urandom) << 32) | 64'($urandom);
    digits = $sformatf("%0d", val);
    mangle = $urandom_range(99);
    if (mangle < 8)
      digits = {"0", digits};
    else if (mangle < 13)
      digits = "";
    if (mangle >= 13 && mangle < 20) begin
      junk = $urandom_range(1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
      cut  = $urandom_range(digits.len());
      send_text(digits.substr(0, cut - 1));
      send_char(junk);
      send_text(digits.substr(cut, digits.len() - 1));
    end else begin
      send_text(digits);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_and_format();
    send_end();
    send_version("1.2");
  endtask

  // Leading zeros, empty numbers, stray separators and precedence between parts
  task automatic test_number_rules();
    send_version("0.0.0");
    send_version("01.2.3");
    send_version("1.-2.3");
    send_version("1.2.3.4");
    send_version("1.2.");
    send_version("x.y.z");
  endtask

  task automatic test_overflow();
    send_version("4294967295.4294967295.4294967295-rc.1");
    send_version("1.4294967296.0");
    send_version("1.2.99999999999-!");
  endtask

  task automatic test_prerelease();
    send_version("1.2.3-");
    send_version("1.2.3-a_b");
    send_version("1.2.3-alpha.1-B9");
  endtask

  // Mostly well-formed strings with random content, some noise and broken ones
  task automatic test_random_versions(int unsigned budget);
    int unsigned stop_at;
    int unsigned n;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        n = $urandom_range(12);
        repeat (n) send_char(8'($urandom_range(255)));
      end else begin
        send_random_number();
        if ($urandom_range(99) >= 4) send_char(svp_pkg::CH_DOT);
        send_random_number();
        if ($urandom_range(99) >= 4) send_char(svp_pkg::CH_DOT);
        send_random_number();
        if ($urandom_range(1)) begin
          send_char(svp_pkg::CH_DASH);
          n = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 12);
          repeat (n) begin
            if ($urandom_range(99) < 8) begin
              send_char(8'($urandom_range(255)));
            end else begin
              case ($urandom_range(4))
                0:       send_char(svp_pkg::CH_LA + 8'($urandom_range(25)));
                1:       send_char(svp_pkg::CH_UA + 8'($urandom_range(25)));
                2:       send_char(svp_pkg::CH_0 + 8'($urandom_range(9)));
                3:       send_char(svp_pkg::CH_DOT);
                default: send_char(svp_pkg::CH_DASH);
              endcase
            end
          end
        end
      end
      send_end();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    svp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_versions.size() == 0) begin
        $error("result transfer with no version string outstanding");
        fail_count++;
      end else begin
        want = expected_versions.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("major_value", want.major_value, out_data.major_value);
        check_field("minor_value", want.minor_value, out_data.minor_value);
        check_field("patch_value", want.patch_value, out_data.patch_value);
        check_field("has_prerelease", 32'(want.has_prerelease),
                    32'(out_data.has_prerelease));
        check_field("prerelease_length", 32'(want.prerelease_length),
                    32'(out_data.prerelease_length));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // slow receiver
    send_idle_pct = 7;
    recv_idle_pct = 69;
    test_empty_and_format();
    test_number_rules();
    test_overflow();
    test_prerelease();
    test_random_versions(430);

    // slow sender
    send_idle_pct = 69;
    recv_idle_pct = 7;
    test_random_versions(430);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_versions(440);

    in_valid <= 1'b0;
    while (expected_versions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
